// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk with rst_n as disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/upqd_pkg.sv =====
// ----------------------------------------------------------------------------
// upqd_pkg
// Types, character codes and hex helpers for the path/query percent decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package upqd_pkg;

    localparam int MaxResults = 4;
    localparam int IdxW       = $clog2(MaxResults);
    localparam int CntW       = $clog2(MaxResults + 1);

    localparam logic [7:0] CharPct   = 8'h25;
    localparam logic [7:0] CharQmark = 8'h3F;
    localparam logic [7:0] CharEq    = 8'h3D;
    localparam logic [7:0] CharAmp   = 8'h26;
    localparam logic [7:0] Char0     = 8'h30;
    localparam logic [7:0] Char9     = 8'h39;
    localparam logic [7:0] CharUA    = 8'h41;
    localparam logic [7:0] CharUF    = 8'h46;
    localparam logic [7:0] CharLA    = 8'h61;
    localparam logic [7:0] CharLF    = 8'h66;
    localparam logic [7:0] HexTen    = 8'd10;

    // token kind, also used as section code
    localparam logic [1:0] KIND_PATH  = 2'd0;
    localparam logic [1:0] KIND_KEY   = 2'd1;
    localparam logic [1:0] KIND_VALUE = 2'd2;

    localparam logic [1:0] HELD_NONE  = 2'd0;
    localparam logic [1:0] HELD_PCT   = 2'd1;
    localparam logic [1:0] HELD_DIGIT = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       valid;
        logic       tend;
    } res_t;

    typedef struct packed {
        res_t [MaxResults-1:0] ent;
        logic [CntW-1:0]       n;
    } res_list_t;

    typedef struct packed {
        logic [1:0] section;
        logic [1:0] held_count;
        logic [7:0] held_digit;
        logic       has_content;
    } dec_state_t;

    function automatic logic is_hex(logic [7:0] c);
        return (c >= Char0 && c <= Char9) || (c >= CharUA && c <= CharUF) ||
               (c >= CharLA && c <= CharLF);
    endfunction

    function automatic logic [3:0] hex_value(logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c >= Char0 && c <= Char9)
        begin
            v = c - Char0;
        end
        else if (c >= CharUA && c <= CharUF)
        begin
            v = c - CharUA + HexTen;
        end
        else if (c >= CharLA && c <= CharLF)
        begin
            v = c - CharLA + HexTen;
        end
        return v[3:0];
    endfunction

endpackage

// ===== rtl/upqd_if.sv =====
// ----------------------------------------------------------------------------
// upqd_if
// Valid/ready channels: raw path bytes in, tagged decoded words out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface upqd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, in_byte, in_last, input ready);
    modport sink   (input valid, in_byte, in_last, output ready);
endinterface

interface upqd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] token_kind;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       token_end;
    logic       run_last;

    modport source (output valid, token_kind, data_byte, byte_valid, token_end, run_last,
                    input ready);
    modport sink   (input valid, token_kind, data_byte, byte_valid, token_end, run_last,
                    output ready);
endinterface

// ===== rtl/url_path_query_percent_decoder.sv =====
// ----------------------------------------------------------------------------
// url_path_query_percent_decoder
// Splits a request path into path, query keys and values, percent-decodes
// each token and tags every output word with its token kind.
// ----------------------------------------------------------------------------
// Channel   Dir   Payload
// raw       in    in_byte[7:0], in_last
// token     out   token_kind[1:0], data_byte[7:0], byte_valid, token_end, run_last
//
// One input word per cycle while the receiver is ready and each byte yields at
// most one output word. A byte that yields N words (up to 4, at flushes and token
// ends) holds the output buffer until its last word is sent; the input register
// takes a byte meanwhile. A raw byte passes the input register, then the result buffer.
// Reset returns to the path section with nothing held; no reset sweep.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module url_path_query_percent_decoder (
    input  logic      clk,
    input  logic      rst_n,
    upqd_in_if.sink   raw,
    upqd_out_if.source token
);

    logic                 in_full_reg;
    logic [7:0]           in_byte_reg;
    logic                 in_last_reg;
    upqd_pkg::dec_state_t st_reg;
    upqd_pkg::dec_state_t st_next;
    upqd_pkg::res_list_t  step_lst;
    logic                 can_load;
    logic                 consume;

    assign consume   = in_full_reg && can_load;
    assign raw.ready = !in_full_reg || consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg        <= 1'b0;
            st_reg.section     <= upqd_pkg::KIND_PATH;
            st_reg.held_count  <= upqd_pkg::HELD_NONE;
            st_reg.held_digit  <= 8'd0;
            st_reg.has_content <= 1'b0;
        end
        else
        begin
            if (raw.valid && raw.ready)
            begin
                in_full_reg <= 1'b1;
            end
            else if (consume)
            begin
                in_full_reg <= 1'b0;
            end
            if (consume)
            begin
                st_reg <= st_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (raw.valid && raw.ready)
        begin
            in_byte_reg <= raw.in_byte;
            in_last_reg <= raw.in_last;
        end
    end

    upqd_step u_step (
        .cur     (st_reg),
        .in_byte (in_byte_reg),
        .in_last (in_last_reg),
        .nxt     (st_next),
        .lst     (step_lst)
    );

    upqd_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (consume),
        .lst      (step_lst),
        .can_load (can_load),
        .token    (token)
    );

    `ASSERT_NEXT(a_last_clears_state, consume && in_last_reg,
                 st_reg.section == upqd_pkg::KIND_PATH &&
                 st_reg.held_count == upqd_pkg::HELD_NONE && !st_reg.has_content)
    `ASSERT_NEXT(a_stalled_input_holds, in_full_reg && !consume,
                 in_full_reg && $stable(in_byte_reg) && $stable(in_last_reg))
    `ASSERT_SAME(a_digit_cleared, st_reg.held_count != upqd_pkg::HELD_DIGIT,
                 st_reg.held_digit == 8'd0)

endmodule

// ===== rtl/upqd_step.sv =====
// ----------------------------------------------------------------------------
// upqd_step
// One byte step: splits sections, percent-decodes, builds the result list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module upqd_step (
    input  upqd_pkg::dec_state_t cur,
    input  logic [7:0]           in_byte,
    input  logic                 in_last,
    output upqd_pkg::dec_state_t nxt,
    output upqd_pkg::res_list_t  lst
);

    typedef struct packed {
        upqd_pkg::res_list_t lst;
        logic [1:0]          hc;
        logic [7:0]          hd;
    } work_t;

    function automatic work_t push_res(work_t w, logic [1:0] kind, logic [7:0] data,
                                       logic valid, logic tend);
        work_t r;
        r = w;
        if (r.lst.n < upqd_pkg::CntW'(upqd_pkg::MaxResults))
        begin
            r.lst.ent[r.lst.n[upqd_pkg::IdxW-1:0]].kind  = kind;
            r.lst.ent[r.lst.n[upqd_pkg::IdxW-1:0]].data  = data;
            r.lst.ent[r.lst.n[upqd_pkg::IdxW-1:0]].valid = valid;
            r.lst.ent[r.lst.n[upqd_pkg::IdxW-1:0]].tend  = tend;
            r.lst.n = r.lst.n + upqd_pkg::CntW'(1);
        end
        return r;
    endfunction

    function automatic work_t plain(work_t w, logic [1:0] kind, logic [7:0] b);
        work_t r;
        r = w;
        if (b == upqd_pkg::CharPct)
        begin
            r.hc = upqd_pkg::HELD_PCT;
        end
        else
        begin
            r = push_res(r, kind, b, 1'b1, 1'b0);
        end
        return r;
    endfunction

    function automatic work_t decode(work_t w, logic [1:0] kind, logic [7:0] b);
        work_t r;
        r = w;
        if (r.hc == upqd_pkg::HELD_NONE)
        begin
            r = plain(r, kind, b);
        end
        else if (r.hc == upqd_pkg::HELD_PCT)
        begin
            if (upqd_pkg::is_hex(b))
            begin
                r.hd = b;
                r.hc = upqd_pkg::HELD_DIGIT;
            end
            else
            begin
                r = push_res(r, kind, upqd_pkg::CharPct, 1'b1, 1'b0);
                r.hc = upqd_pkg::HELD_NONE;
                r = plain(r, kind, b);
            end
        end
        else
        begin
            if (upqd_pkg::is_hex(b))
            begin
                r = push_res(r, kind, {upqd_pkg::hex_value(r.hd), upqd_pkg::hex_value(b)},
                             1'b1, 1'b0);
                r.hc = upqd_pkg::HELD_NONE;
            end
            else
            begin
                r = push_res(r, kind, upqd_pkg::CharPct, 1'b1, 1'b0);
                r = push_res(r, kind, r.hd, 1'b1, 1'b0);
                r.hc = upqd_pkg::HELD_NONE;
                r = plain(r, kind, b);
            end
            r.hd = 8'd0;
        end
        return r;
    endfunction

    function automatic work_t flush(work_t w, logic [1:0] kind);
        work_t r;
        r = w;
        if (r.hc >= upqd_pkg::HELD_PCT)
        begin
            r = push_res(r, kind, upqd_pkg::CharPct, 1'b1, 1'b0);
        end
        if (r.hc >= upqd_pkg::HELD_DIGIT)
        begin
            r = push_res(r, kind, r.hd, 1'b1, 1'b0);
        end
        r.hc = upqd_pkg::HELD_NONE;
        r.hd = 8'd0;
        return r;
    endfunction

    // mark the previous word as token end, else add a bare end marker
    function automatic work_t end_token(work_t w, logic [1:0] kind);
        work_t                     r;
        logic [upqd_pkg::IdxW-1:0] k;
        r = w;
        k = upqd_pkg::IdxW'(r.lst.n - upqd_pkg::CntW'(1));
        if (r.lst.n != '0 && r.lst.ent[k].valid && r.lst.ent[k].kind == kind &&
            !r.lst.ent[k].tend)
        begin
            r.lst.ent[k].tend = 1'b1;
        end
        else
        begin
            r = push_res(r, kind, 8'd0, 1'b0, 1'b1);
        end
        return r;
    endfunction

    work_t      w;
    logic [1:0] sec;
    logic       ehc;

    always_comb
    begin
        w     = '0;
        w.hc  = cur.held_count;
        w.hd  = cur.held_digit;
        sec   = cur.section;
        ehc   = cur.has_content;

        if (sec == upqd_pkg::KIND_KEY)
        begin
            if (in_byte == upqd_pkg::CharAmp)
            begin
                if (ehc)
                begin
                    w = flush(w, upqd_pkg::KIND_KEY);
                    w = end_token(w, upqd_pkg::KIND_KEY);
                    w = end_token(w, upqd_pkg::KIND_VALUE);
                end
                ehc = 1'b0;
            end
            else if (in_byte == upqd_pkg::CharEq)
            begin
                w   = flush(w, upqd_pkg::KIND_KEY);
                w   = end_token(w, upqd_pkg::KIND_KEY);
                sec = upqd_pkg::KIND_VALUE;
                ehc = 1'b1;
            end
            else
            begin
                ehc = 1'b1;
                w   = decode(w, upqd_pkg::KIND_KEY, in_byte);
            end
        end
        else if (sec == upqd_pkg::KIND_VALUE)
        begin
            if (in_byte == upqd_pkg::CharAmp)
            begin
                w   = flush(w, upqd_pkg::KIND_VALUE);
                w   = end_token(w, upqd_pkg::KIND_VALUE);
                sec = upqd_pkg::KIND_KEY;
                ehc = 1'b0;
            end
            else
            begin
                w = decode(w, upqd_pkg::KIND_VALUE, in_byte);
            end
        end
        else
        begin
            if (in_byte == upqd_pkg::CharQmark)
            begin
                w   = flush(w, upqd_pkg::KIND_PATH);
                w   = end_token(w, upqd_pkg::KIND_PATH);
                sec = upqd_pkg::KIND_KEY;
                ehc = 1'b0;
            end
            else
            begin
                w = decode(w, upqd_pkg::KIND_PATH, in_byte);
            end
        end

        if (in_last)
        begin
            if (sec == upqd_pkg::KIND_KEY)
            begin
                if (ehc)
                begin
                    w = flush(w, upqd_pkg::KIND_KEY);
                    w = end_token(w, upqd_pkg::KIND_KEY);
                    w = end_token(w, upqd_pkg::KIND_VALUE);
                end
            end
            else if (sec == upqd_pkg::KIND_VALUE)
            begin
                w = flush(w, upqd_pkg::KIND_VALUE);
                w = end_token(w, upqd_pkg::KIND_VALUE);
            end
            else
            begin
                w = flush(w, upqd_pkg::KIND_PATH);
                w = end_token(w, upqd_pkg::KIND_PATH);
            end
            sec  = upqd_pkg::KIND_PATH;
            ehc  = 1'b0;
            w.hc = upqd_pkg::HELD_NONE;
            w.hd = 8'd0;
        end

        lst             = w.lst;
        nxt.section     = sec;
        nxt.held_count  = w.hc;
        nxt.held_digit  = w.hd;
        nxt.has_content = ehc;
    end

endmodule

// ===== rtl/upqd_emit.sv =====
// ----------------------------------------------------------------------------
// upqd_emit
// Result buffer: holds one step's words and sends them one per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module upqd_emit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  upqd_pkg::res_list_t lst,
    output logic                can_load,
    upqd_out_if.source          token
);

    upqd_pkg::res_t [upqd_pkg::MaxResults-1:0] ent_reg;
    logic [upqd_pkg::CntW-1:0]                 n_reg;
    logic [upqd_pkg::IdxW-1:0]                 idx_reg;
    logic [upqd_pkg::IdxW-1:0]                 last_idx;
    logic                                      fire;
    logic                                      done;

    assign last_idx = upqd_pkg::IdxW'(n_reg - upqd_pkg::CntW'(1));
    assign fire     = token.valid && token.ready;
    assign done     = fire && (idx_reg == last_idx);
    assign can_load = (n_reg == '0) || done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg   <= '0;
            idx_reg <= '0;
        end
        else if (load)
        begin
            n_reg   <= lst.n;
            idx_reg <= '0;
        end
        else if (done)
        begin
            n_reg   <= '0;
            idx_reg <= '0;
        end
        else if (fire)
        begin
            idx_reg <= idx_reg + upqd_pkg::IdxW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ent_reg <= lst.ent;
        end
    end

    assign token.valid      = (n_reg != '0);
    assign token.token_kind = ent_reg[idx_reg].kind;
    assign token.data_byte  = ent_reg[idx_reg].data;
    assign token.byte_valid = ent_reg[idx_reg].valid;
    assign token.token_end  = ent_reg[idx_reg].tend;
    assign token.run_last   = (idx_reg == last_idx);

endmodule

// ===== test/upqd_checker.sv =====
// ----------------------------------------------------------------------------
// upqd_checker
// Watches the raw and token channels of the path/query decoder, keeps its own
// model of the decoder state, queues the words each accepted byte should give
// and compares every accepted token word against the oldest one queued.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module upqd_checker (
    input  logic clk,
    input  logic rst_n,
    upqd_in_if   raw,
    upqd_out_if  token,
    output int   fail_count,
    output int   pending_words,
    output int   words_checked
);
    import upqd_pkg::*;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       bvalid;
        logic       tend;
        logic       rlast;
    } token_word_t;

    token_word_t due_words[$];
    token_word_t step_words[$];
    token_word_t want;

    logic [1:0] section;
    logic [1:0] held_count;
    logic [7:0] held_digit;
    logic       has_content;

    function automatic logic hex_char(input logic [7:0] c);
        return (c >= Char0 && c <= Char9) || (c >= CharUA && c <= CharUF) ||
               (c >= CharLA && c <= CharLF);
    endfunction

    // digits keep their low nibble, letters of either case sit 9 below
    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        if (c <= Char9)
            return c[3:0];
        return c[3:0] + 4'd9;
    endfunction

    task automatic emit(input logic [1:0] kind, input logic [7:0] data,
                        input logic bvalid, input logic tend);
        token_word_t w;
        w.kind   = kind;
        w.data   = data;
        w.bvalid = bvalid;
        w.tend   = tend;
        w.rlast  = 1'b0;
        if (step_words.size() < MaxResults)
            step_words.push_back(w);
    endtask

    task automatic literal_char(input logic [1:0] kind, input logic [7:0] c);
        if (c == CharPct)
            held_count = HELD_PCT;
        else
            emit(kind, c, 1'b1, 1'b0);
    endtask

    task automatic take_char(input logic [1:0] kind, input logic [7:0] c);
        if (held_count == HELD_NONE)
        begin
            literal_char(kind, c);
        end
        else if (held_count == HELD_PCT)
        begin
            if (hex_char(c))
            begin
                held_digit = c;
                held_count = HELD_DIGIT;
            end
            else
            begin
                emit(kind, CharPct, 1'b1, 1'b0);
                held_count = HELD_NONE;
                literal_char(kind, c);
            end
        end
        else
        begin
            if (hex_char(c))
            begin
                emit(kind, {nibble_of(held_digit), nibble_of(c)}, 1'b1, 1'b0);
                held_count = HELD_NONE;
            end
            else
            begin
                emit(kind, CharPct, 1'b1, 1'b0);
                emit(kind, held_digit, 1'b1, 1'b0);
                held_count = HELD_NONE;
                literal_char(kind, c);
            end
            held_digit = 8'd0;
        end
    endtask

    task automatic spill_held(input logic [1:0] kind);
        if (held_count != HELD_NONE)
            emit(kind, CharPct, 1'b1, 1'b0);
        if (held_count == HELD_DIGIT)
            emit(kind, held_digit, 1'b1, 1'b0);
        held_count = HELD_NONE;
        held_digit = 8'd0;
    endtask

    // mark the end on this step's last word if it is a byte of the same kind, else a bare marker
    task automatic close_token(input logic [1:0] kind);
        int k;
        k = step_words.size() - 1;
        if (k >= 0 && step_words[k].bvalid && step_words[k].kind == kind &&
            !step_words[k].tend)
            step_words[k].tend = 1'b1;
        else
            emit(kind, 8'd0, 1'b0, 1'b1);
    endtask

    task automatic close_entry();
        spill_held(KIND_KEY);
        close_token(KIND_KEY);
        close_token(KIND_VALUE);
    endtask

    task automatic clear_state();
        section     = KIND_PATH;
        held_count  = HELD_NONE;
        held_digit  = 8'd0;
        has_content = 1'b0;
    endtask

    task automatic split_and_decode(input logic [7:0] c, input logic last);
        step_words.delete();
        case (section)
            KIND_KEY:
            begin
                if (c == CharAmp)
                begin
                    if (has_content)
                        close_entry();
                    has_content = 1'b0;
                end
                else if (c == CharEq)
                begin
                    spill_held(KIND_KEY);
                    close_token(KIND_KEY);
                    section     = KIND_VALUE;
                    has_content = 1'b1;
                end
                else
                begin
                    has_content = 1'b1;
                    take_char(KIND_KEY, c);
                end
            end
            KIND_VALUE:
            begin
                if (c == CharAmp)
                begin
                    spill_held(KIND_VALUE);
                    close_token(KIND_VALUE);
                    section     = KIND_KEY;
                    has_content = 1'b0;
                end
                else
                begin
                    take_char(KIND_VALUE, c);
                end
            end
            default:
            begin
                if (c == CharQmark)
                begin
                    spill_held(KIND_PATH);
                    close_token(KIND_PATH);
                    section     = KIND_KEY;
                    has_content = 1'b0;
                end
                else
                begin
                    take_char(KIND_PATH, c);
                end
            end
        endcase
        if (last)
        begin
            case (section)
                KIND_KEY:
                begin
                    if (has_content)
                        close_entry();
                end
                KIND_VALUE:
                begin
                    spill_held(KIND_VALUE);
                    close_token(KIND_VALUE);
                end
                default:
                begin
                    spill_held(KIND_PATH);
                    close_token(KIND_PATH);
                end
            endcase
            clear_state();
        end
        foreach (step_words[i])
        begin
            step_words[i].rlast = (i == step_words.size() - 1);
            due_words.push_back(step_words[i]);
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        fail_count++;
        $display("[%0t] word %0d %s: got 0x%0h, want 0x%0h",
                 $realtime, words_checked, what, got, exp_val);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_state();
            due_words.delete();
            fail_count    = 0;
            words_checked = 0;
        end
        else
        begin
            if (raw.valid && raw.ready)
                split_and_decode(raw.in_byte, raw.in_last);
            if (token.valid && token.ready)
            begin
                if (due_words.size() == 0)
                begin
                    report_mismatch("unexpected word, data", token.data_byte, 0);
                end
                else
                begin
                    want = due_words.pop_front();
                    if (token.token_kind !== want.kind)
                        report_mismatch("token_kind", token.token_kind, want.kind);
                    if (token.data_byte !== want.data)
                        report_mismatch("data_byte", token.data_byte, want.data);
                    if (token.byte_valid !== want.bvalid)
                        report_mismatch("byte_valid", token.byte_valid, want.bvalid);
                    if (token.token_end !== want.tend)
                        report_mismatch("token_end", token.token_end, want.tend);
                    if (token.run_last !== want.rlast)
                        report_mismatch("run_last", token.run_last, want.rlast);
                end
                words_checked++;
            end
        end
        pending_words = due_words.size();
    end

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives request paths into the percent decoder: a directed set of corner
// cases, then random requests built from escapes, delimiters and noise, with
// random idling on both channels, a long receiver stall and sender drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import upqd_pkg::*;

    localparam int QuietLimit = 1000;
    localparam int StallCycles = 80;
    localparam int RandomBytes = 300;

    logic clk = 1'b0;
    logic rst_n;

    logic idle_on;
    logic stall_req;
    int   bytes_sent;
    int   requests_sent;
    int   quiet_cycles;
    int   fail_count;
    int   pending_words;
    int   words_checked;

    upqd_in_if  raw_ch ();
    upqd_out_if token_ch ();

    url_path_query_percent_decoder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .raw   (raw_ch),
        .token (token_ch)
    );

    upqd_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .raw           (raw_ch),
        .token         (token_ch),
        .fail_count    (fail_count),
        .pending_words (pending_words),
        .words_checked (words_checked)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // receiver: random backpressure, plus one long hold-off on request
    initial
    begin
        int   stall_left;
        logic stall_done;
        stall_left     = 0;
        stall_done     = 1'b0;
        token_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                token_ch.ready = 1'b0;
                stall_left--;
            end
            else if (stall_req && !stall_done)
            begin
                stall_done     = 1'b1;
                stall_left     = StallCycles - 1;
                token_ch.ready = 1'b0;
            end
            else
            begin
                token_ch.ready = !(idle_on && $urandom_range(99) < 12);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (raw_ch.valid && raw_ch.ready) || (token_ch.valid && token_ch.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QuietLimit)
            begin
                $display("timeout: no word moved for %0d cycles", QuietLimit);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic send_word(input logic [7:0] c, input logic last);
        while (idle_on && $urandom_range(99) < 12)
        begin
            raw_ch.valid = 1'b0;
            @(negedge clk);
        end
        raw_ch.valid   = 1'b1;
        raw_ch.in_byte = c;
        raw_ch.in_last = last;
        @(posedge clk);
        while (!raw_ch.ready)
            @(posedge clk);
        bytes_sent++;
        if (last)
            requests_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], i == s.len() - 1);
    endtask

    task automatic drain();
        raw_ch.valid = 1'b0;
        while (pending_words != 0)
            @(negedge clk);
    endtask

    function automatic logic [7:0] any_hex();
        int r;
        r = $urandom_range(21);
        if (r < 10)
            return Char0 + 8'(r);
        if (r < 16)
            return CharUA + 8'(r - 10);
        return CharLA + 8'(r - 16);
    endfunction

    // 'g'..'z', never a hex digit
    function automatic logic [7:0] non_hex();
        return CharLF + 8'd1 + 8'($urandom_range(19));
    endfunction

    task automatic send_request();
        logic [7:0] text[$];
        int         pick;
        repeat ($urandom_range(1, 10))
        begin
            pick = $urandom_range(99);
            if (pick < 30)
            begin
                text.push_back(($urandom_range(1)) ? non_hex() : any_hex());
            end
            else if (pick < 42)
            begin
                text.push_back(CharPct);
                text.push_back(any_hex());
                text.push_back(any_hex());
            end
            else if (pick < 48)
            begin
                text.push_back(CharPct);
                if ($urandom_range(1))
                    text.push_back(any_hex());
                if ($urandom_range(1))
                    text.push_back(($urandom_range(1)) ? non_hex() : CharPct);
            end
            else if (pick < 58)
            begin
                text.push_back(CharQmark);
            end
            else if (pick < 70)
            begin
                text.push_back(CharAmp);
            end
            else if (pick < 82)
            begin
                text.push_back(CharEq);
            end
            else
            begin
                text.push_back(8'($urandom_range(255)));
            end
        end
        foreach (text[i])
            send_word(text[i], i == text.size() - 1);
    endtask

    initial
    begin
        int   rand_start;
        logic paused;
        rst_n          = 1'b0;
        raw_ch.valid   = 1'b0;
        raw_ch.in_byte = 8'd0;
        raw_ch.in_last = 1'b0;
        idle_on        = 1'b0;
        stall_req      = 1'b0;
        bytes_sent     = 0;
        requests_sent  = 0;
        paused         = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // empty path and query; mixed-case escape; delimiters out of section,
        // zero byte, broken escapes, empty key, '=' and '?' in a value, a held
        // digit cut off by 'z', trailing '%' at the end of a key
        idle_on = 1'b1;
        send_text("?");
        send_text("%Fa");
        send_text("a&%00%%4?=x=?&k%4z&y%");
        drain();

        idle_on    = 1'b0;
        rand_start = bytes_sent;
        while (bytes_sent < rand_start + RandomBytes)
        begin
            if (bytes_sent >= rand_start + 100)
                idle_on = 1'b1;
            if (bytes_sent >= rand_start + 150)
                stall_req = 1'b1;
            if (!paused && bytes_sent >= rand_start + 230)
            begin
                paused = 1'b1;
                drain();
            end
            send_request();
        end
        drain();
        repeat (8) @(negedge clk);

        $display("Summary: %0d raw bytes in %0d requests, %0d token words compared",
                 bytes_sent, requests_sent, words_checked);
        $display("Covered escapes, broken escapes, empty tokens, a long output stall");
        if (fail_count == 0 && pending_words == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/upqd_pkg.sv
rtl/upqd_if.sv
rtl/upqd_step.sv
rtl/upqd_emit.sv
rtl/url_path_query_percent_decoder.sv
test/upqd_checker.sv
test/tb.sv
